@@ rtl/core/rgbyuv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rgbyuv_pkg;

    // Per-pixel chroma in 8.16 fixed point, clamped to 0..255
    localparam int FIX_W      = 24;
    // Sum of two clamped 8.16 values
    localparam int PAIR_SUM_W = FIX_W + 1;
    localparam logic [FIX_W-1:0] FIX_MAX = 24'hFF0000;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // What the back end does with a pixel's chroma
    typedef enum logic [1:0] {
        KIND_LEFT,   // even column: hold as left neighbor
        KIND_STORE,  // odd column of an even row: store the pair sum
        KIND_CLOSE   // odd column of an odd row: close the 2x2 block
    } t_kind;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_pixel_out;

    // Classified, converted pixel handed from front to back
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       luma;
        logic [FIX_W-1:0] u_fix;
        logic [FIX_W-1:0] v_fix;
    } t_work;

endpackage

`default_nettype wire

@@ rtl/core/rgbyuv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11,
    parameter int PAIR_W    = 10
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  rgbyuv_pkg::t_pixel_in    i_pixel,
    output logic                     o_full,
    input  wire [11:0]               i_line_width,
    output logic                     o_valid,
    output rgbyuv_pkg::t_work        o_work,
    output logic [PAIR_W-1:0]        o_pair,
    input  wire                      i_ready
);

    import rgbyuv_pkg::*;

    localparam int PROD_W = 26;
    localparam int SUM_W  = 28;
    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

    localparam logic signed [PROD_W-1:0] C_YR = 26'sd19589;
    localparam logic signed [PROD_W-1:0] C_YG = 26'sd38443;
    localparam logic signed [PROD_W-1:0] C_YB = 26'sd7504;
    localparam logic signed [PROD_W-1:0] C_UR = -26'sd11062;
    localparam logic signed [PROD_W-1:0] C_UG = -26'sd21706;
    localparam logic signed [PROD_W-1:0] C_UB = 26'sd32768;
    localparam logic signed [PROD_W-1:0] C_VR = 26'sd32768;
    localparam logic signed [PROD_W-1:0] C_VG = -26'sd27420;
    localparam logic signed [PROD_W-1:0] C_VB = -26'sd5348;
    localparam logic signed [SUM_W-1:0]  C_HALF = 28'sd8388608;
    localparam logic signed [SUM_W-1:0]  FIX_MAX_S = SUM_W'(FIX_MAX);

    function automatic logic [FIX_W-1:0] clamp_fix(input logic signed [SUM_W-1:0] s);
        logic [FIX_W-1:0] res;
        if (s < 0) begin
            res = '0;
        end else if (s > FIX_MAX_S) begin
            res = FIX_MAX;
        end else begin
            res = s[FIX_W-1:0];
        end
        return res;
    endfunction

    // Position tracking
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_row_odd, n_row_odd;

    // Stage 1: products and classification
    logic                     r_s1_valid;
    t_kind                    r_s1_kind;
    logic [PAIR_W-1:0]        r_s1_pair;
    logic signed [PROD_W-1:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;

    // Stage 2: clamped values
    logic              r_s2_valid;
    t_work             r_s2_work;
    logic [PAIR_W-1:0] r_s2_pair;

    logic              s1_ready, s2_ready, accept;
    logic [COL_W-1:0]  x;
    logic              odd_row;
    logic [WCMP_W-1:0] lw_ext, eff_width;
    logic [WCMP_W:0]   x_next;
    logic [COL_W-1:0]  pair_full;
    t_kind             kind;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
    logic [FIX_W-1:0]  y_fix;

    // Stall control
    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign accept   = i_push && s1_ready;
    assign o_full   = !s1_ready;

    // Clamp the configured width and work out this pixel's position
    always_comb begin
        lw_ext = WCMP_W'(i_line_width);
        if (lw_ext < WCMP_W'(2)) begin
            eff_width = WCMP_W'(2);
        end else if (lw_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_width = WCMP_W'(MAX_WIDTH);
        end else begin
            eff_width = lw_ext;
        end
        x       = i_pixel.frame_start ? '0 : r_col;
        odd_row = i_pixel.frame_start ? 1'b0 : r_row_odd;
        x_next  = (WCMP_W + 1)'(x) + (WCMP_W + 1)'(1);
        if (x_next >= {1'b0, eff_width}) begin
            n_col     = '0;
            n_row_odd = !odd_row;
        end else begin
            n_col     = x_next[COL_W-1:0];
            n_row_odd = odd_row;
        end
        pair_full = x >> 1;
        if (!x[0]) begin
            kind = KIND_LEFT;
        end else if (!odd_row) begin
            kind = KIND_STORE;
        end else begin
            kind = KIND_CLOSE;
        end
    end

    // Advance position on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_odd <= 1'b0;
        end else if (accept) begin
            r_col     <= n_col;
            r_row_odd <= n_row_odd;
        end
    end

    // Stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_push;
        end
    end

    // Stage 1 payload: coefficient products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= kind;
            r_s1_pair <= pair_full[PAIR_W-1:0];
            r_yr <= $signed({1'b0, i_pixel.red})   * C_YR;
            r_yg <= $signed({1'b0, i_pixel.green}) * C_YG;
            r_yb <= $signed({1'b0, i_pixel.blue})  * C_YB;
            r_ur <= $signed({1'b0, i_pixel.red})   * C_UR;
            r_ug <= $signed({1'b0, i_pixel.green}) * C_UG;
            r_ub <= $signed({1'b0, i_pixel.blue})  * C_UB;
            r_vr <= $signed({1'b0, i_pixel.red})   * C_VR;
            r_vg <= $signed({1'b0, i_pixel.green}) * C_VG;
            r_vb <= $signed({1'b0, i_pixel.blue})  * C_VB;
        end
    end

    // Sum the products and clamp to 0..255 in 8.16
    always_comb begin
        y_sum = SUM_W'(r_yr) + SUM_W'(r_yg) + SUM_W'(r_yb);
        u_sum = SUM_W'(r_ur) + SUM_W'(r_ug) + SUM_W'(r_ub) + C_HALF;
        v_sum = SUM_W'(r_vr) + SUM_W'(r_vg) + SUM_W'(r_vb) + C_HALF;
        y_fix = clamp_fix(y_sum);
    end

    // Stage 2 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 2 payload
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_s2_work.kind  <= r_s1_kind;
            r_s2_work.luma  <= y_fix[FIX_W-1:16];
            r_s2_work.u_fix <= clamp_fix(u_sum);
            r_s2_work.v_fix <= clamp_fix(v_sum);
            r_s2_pair       <= r_s1_pair;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_work  = r_s2_work;
    assign o_pair  = r_s2_pair;

endmodule

`default_nettype wire

@@ rtl/core/rgbyuv_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_queue #(
    parameter int DATA_W = 68
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire [DATA_W-1:0]  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  wire               i_pop
);

    import rgbyuv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Hold the request payloads
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rgbyuv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_back #(
    parameter int PAIR_W     = 10,
    parameter int PAIR_DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  rgbyuv_pkg::t_work        i_work,
    input  wire [PAIR_W-1:0]         i_pair,
    output logic                     o_ready,
    output logic                     o_empty,
    output rgbyuv_pkg::t_pixel_out   o_result,
    input  wire                      i_pop
);

    import rgbyuv_pkg::*;

    localparam int BLK_W = PAIR_SUM_W + 1;

    // Line store: {cb pair sum, cr pair sum} of the last even row
    logic [2*PAIR_SUM_W-1:0] r_line [PAIR_DEPTH];

    logic [FIX_W-1:0]      r_left_cb, r_left_cr;

    logic                  r_b1_valid;
    t_kind                 r_b1_kind;
    logic [7:0]            r_b1_luma;
    logic [PAIR_SUM_W-1:0] r_b1_cb_part, r_b1_cr_part;
    logic [2*PAIR_SUM_W-1:0] r_b1_line;

    logic                  r_b2_valid;
    t_pixel_out            r_b2_result;

    logic                  b1_ready, b2_ready, load1;
    logic [PAIR_SUM_W-1:0] cb_part, cr_part;
    logic [BLK_W-1:0]      cb_block, cr_block;
    t_pixel_out            result;

    // Stall control
    assign b2_ready = !r_b2_valid || i_pop;
    assign b1_ready = !r_b1_valid || b2_ready;
    assign o_ready  = b1_ready;
    assign load1    = i_valid && b1_ready;

    // Pair sums with the left neighbor
    assign cb_part = PAIR_SUM_W'(r_left_cb) + PAIR_SUM_W'(i_work.u_fix);
    assign cr_part = PAIR_SUM_W'(r_left_cr) + PAIR_SUM_W'(i_work.v_fix);

    // Hold the left neighbor's chroma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cb <= '0;
            r_left_cr <= '0;
        end else if (load1 && i_work.kind == KIND_LEFT) begin
            r_left_cb <= i_work.u_fix;
            r_left_cr <= i_work.v_fix;
        end
    end

    // Line store: write on even rows, registered read for odd rows
    always_ff @(posedge i_clk) begin
        if (load1) begin
            if (i_work.kind == KIND_STORE) begin
                r_line[i_pair] <= {cb_part, cr_part};
            end
            r_b1_line <= r_line[i_pair];
        end
    end

    // Stage B1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (b1_ready) begin
            r_b1_valid <= i_valid;
        end
    end

    // Stage B1 payload
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_b1_kind    <= i_work.kind;
            r_b1_luma    <= i_work.luma;
            r_b1_cb_part <= cb_part;
            r_b1_cr_part <= cr_part;
        end
    end

    // Close the 2x2 block
    always_comb begin
        cb_block = BLK_W'(r_b1_line[2*PAIR_SUM_W-1:PAIR_SUM_W]) + BLK_W'(r_b1_cb_part);
        cr_block = BLK_W'(r_b1_line[PAIR_SUM_W-1:0]) + BLK_W'(r_b1_cr_part);
        result.luma = r_b1_luma;
        case (r_b1_kind)
            KIND_CLOSE: begin
                result.chroma_valid = 1'b1;
                result.cb           = cb_block[BLK_W-1:BLK_W-8];
                result.cr           = cr_block[BLK_W-1:BLK_W-8];
            end
            default: begin
                result.chroma_valid = 1'b0;
                result.cb           = '0;
                result.cr           = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (b2_ready) begin
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b1_valid && b2_ready) begin
            r_b2_result <= result;
        end
    end

    assign o_empty  = !r_b2_valid;
    assign o_result = r_b2_result;

endmodule

`default_nettype wire

@@ rtl/core/rgb_to_yuv420_converter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// RGB to YUV 4:2:0 converter. Pixels are pushed in raster order, one per clock
// while full is low, and every pixel gives one result: its luma, plus the mean
// Cb and Cr of the 2x2 block that it closes at odd columns of odd rows (zero
// otherwise). A sustained rate of one pixel per clock holds while results are
// popped. The rate is set by the single-port line store, which takes one access
// per pixel. frame_start restarts row and column. The line width register must
// be written only while no pixel is in flight; the block does not enforce this.
// Widths below 2 act as 2 and widths above MAX_WIDTH act as MAX_WIDTH. The line
// store needs no clearing after reset: odd rows read only entries written by the
// even row before them.
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     push,
    input  rgbyuv_pkg::t_pixel_in   i_pixel,
    output logic                    full,
    output logic                    empty,
    output rgbyuv_pkg::t_pixel_out  o_result,
    input  wire                     pop,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [11:0]              i_cfg_data
);

    import rgbyuv_pkg::*;

    localparam int PAIR_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int PAIR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int Q_W        = PAIR_W + $bits(t_work);

    logic [11:0]       r_line_width;
    logic              w_front_valid, w_front_ready;
    t_work             w_front_work;
    logic [PAIR_W-1:0] w_front_pair;
    logic              w_q_valid, w_q_ready;
    logic [Q_W-1:0]    w_q_data;
    t_work             w_q_work;
    logic [PAIR_W-1:0] w_q_pair;

    // Line width register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 12'd640;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_width <= i_cfg_data;
        end
    end

    rgbyuv_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .PAIR_W    (PAIR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pixel      (i_pixel),
        .o_full       (full),
        .i_line_width (r_line_width),
        .o_valid      (w_front_valid),
        .o_work       (w_front_work),
        .o_pair       (w_front_pair),
        .i_ready      (w_front_ready)
    );

    rgbyuv_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  ({w_front_pair, w_front_work}),
        .o_ready (w_front_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_ready)
    );

    assign w_q_work = t_work'(w_q_data[$bits(t_work)-1:0]);
    assign w_q_pair = w_q_data[Q_W-1:$bits(t_work)];

    rgbyuv_back #(
        .PAIR_W     (PAIR_W),
        .PAIR_DEPTH (PAIR_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_work   (w_q_work),
        .i_pair   (w_q_pair),
        .o_ready  (w_q_ready),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );

    // A result without chroma carries zero Cb and Cr
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.chroma_valid) |-> (o_result.cb == 8'd0 && o_result.cr == 8'd0))
        else $error("chroma nonzero on a result without a closed block");

    // A front request stalled by the queue is held
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_front_valid && !w_front_ready) |=> (w_front_valid && $stable(w_front_work)))
        else $error("front request dropped or changed while stalled");

    // No result is offered on the first cycle out of reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> empty)
        else $error("result offered right after reset");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import rgbyuv_pkg::*;

    localparam int MAX_WIDTH       = 2048;
    localparam int PAIR_DEPTH      = MAX_WIDTH / 2 + 1;
    localparam int NUM_PHASES      = 12;
    localparam int PIXELS_PER_PHASE = 54;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam longint TIMEOUT_NS  = 2_000_000;

    // Q16 conversion coefficients
    localparam int Y_R = 19589;
    localparam int Y_G = 38443;
    localparam int Y_B = 7504;
    localparam int U_R = -11062;
    localparam int U_G = -21706;
    localparam int U_B = 32768;
    localparam int V_R = 32768;
    localparam int V_G = -27420;
    localparam int V_B = -5348;
    localparam int FIX_HALF = 128 << 16;

    typedef enum logic {ROW_PIXEL, ROW_WIDTH} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [11:0] width;
        t_pixel_in   px;
        bit          typed;
        t_pixel_out  want;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [11:0] i_cfg_data  = '0;
    t_pixel_in   i_pixel     = '0;
    wire         full;
    wire         empty;
    wire         o_cfg_ready;
    t_pixel_out  o_result;

    rgb_to_yuv420_converter_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_pixel    (i_pixel),
        .full       (full),
        .empty      (empty),
        .o_result   (o_result),
        .pop        (pop),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Converter state mirrored by the predictor
    logic [PAIR_SUM_W-1:0] cb_pair_sum [PAIR_DEPTH];
    logic [PAIR_SUM_W-1:0] cr_pair_sum [PAIR_DEPTH];
    bit                    pair_written[PAIR_DEPTH];
    logic [FIX_W-1:0]      left_u = '0;
    logic [FIX_W-1:0]      left_v = '0;
    int unsigned           next_column = 0;
    bit                    odd_row = 1'b0;
    logic [11:0]           width_setting = 12'd640;

    t_pixel_out  expected_pixels[$];
    t_stim_row   plan[$];
    int unsigned mismatch_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    function automatic logic [FIX_W-1:0] clamp_fix(input int v);
        if (v < 0) return '0;
        if (v > int'(FIX_MAX)) return FIX_MAX;
        return FIX_W'(v);
    endfunction

    // Convert one pixel and advance the raster position
    function automatic t_pixel_out convert_pixel(input t_pixel_in px);
        t_pixel_out          res;
        int                  r, g, b;
        int unsigned         w, pair;
        logic [FIX_W-1:0]    y_f, u_f, v_f;
        logic [PAIR_SUM_W:0] sum_u, sum_v;
        res = '0;
        w = width_setting;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (px.frame_start) begin
            next_column = 0;
            odd_row = 1'b0;
        end
        r = px.red;
        g = px.green;
        b = px.blue;
        y_f = clamp_fix(Y_R * r + Y_G * g + Y_B * b);
        u_f = clamp_fix(U_R * r + U_G * g + U_B * b + FIX_HALF);
        v_f = clamp_fix(V_R * r + V_G * g + V_B * b + FIX_HALF);
        pair = next_column >> 1;
        if ((next_column & 1) == 0) begin
            left_u = u_f;
            left_v = v_f;
        end else if (!odd_row) begin
            cb_pair_sum[pair] = left_u + u_f;
            cr_pair_sum[pair] = left_v + v_f;
            pair_written[pair] = 1'b1;
        end else begin
            sum_u = cb_pair_sum[pair] + left_u + u_f;
            sum_v = cr_pair_sum[pair] + left_v + v_f;
            res.cb = 8'(sum_u >> 18);
            res.cr = 8'(sum_v >> 18);
            res.chroma_valid = 1'b1;
        end
        if (next_column + 1 >= w) begin
            next_column = 0;
            odd_row = ~odd_row;
        end else begin
            next_column = next_column + 1;
        end
        res.luma = y_f[FIX_W-1:16];
        return res;
    endfunction

    // Favor the ends of the range so clamping is hit often
    function automatic logic [7:0] random_level();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly continuous raster; restart the frame before a read of an unfilled pair
    function automatic t_pixel_in random_pixel();
        t_pixel_in px;
        px.red = random_level();
        px.green = random_level();
        px.blue = random_level();
        px.frame_start = ($urandom_range(39) == 0);
        if (odd_row && (next_column & 1) && !pair_written[next_column >> 1])
            px.frame_start = 1'b1;
        return px;
    endfunction

    function automatic void add_width(input logic [11:0] w);
        t_stim_row row;
        row = '{kind: ROW_WIDTH, width: w, px: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input bit fs,
                                      input bit typed = 1'b0, input logic [7:0] luma = 0,
                                      input bit cv = 1'b0, input logic [7:0] cb = 0,
                                      input logic [7:0] cr = 0);
        t_stim_row row;
        row.kind = ROW_PIXEL;
        row.width = '0;
        row.px = '{red: r, green: g, blue: b, frame_start: fs};
        row.typed = typed;
        row.want = '{luma: luma, chroma_valid: cv, cb: cb, cr: cr};
        plan.push_back(row);
    endfunction

    // Push one pixel request, then record what it should produce
    task automatic send_pixel(input t_pixel_in px, input bit typed, input t_pixel_out want);
        t_pixel_out predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (full);
        predicted = convert_pixel(px);
        expected_pixels.push_back(typed ? want : predicted);
    endtask

    // Drain the pipeline, then write the line width
    task automatic write_width(input logic [11:0] w);
        push <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_setting = w;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check each popped result against the oldest expectation
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && pop && !empty) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result luma %0d valid %0d cb %0d cr %0d",
                             $realtime, o_result.luma, o_result.chroma_valid,
                             o_result.cb, o_result.cr);
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.luma !== want.luma ||
                    o_result.chroma_valid !== want.chroma_valid ||
                    o_result.cb !== want.cb || o_result.cr !== want.cr) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display(
                            "%0t: exp/act luma %0d/%0d valid %0d/%0d cb %0d/%0d cr %0d/%0d",
                            $realtime, want.luma, o_result.luma,
                            want.chroma_valid, o_result.chroma_valid,
                            want.cb, o_result.cb, want.cr, o_result.cr);
                end
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [11:0] phase_widths[NUM_PHASES];

        // Blocks of black and white: mid-gray chroma, extreme luma
        add_width(12'd2);
        add_pixel(0, 0, 0, 1, 1, 0, 0, 0, 0);
        add_pixel(0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_pixel(0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_pixel(0, 0, 0, 0, 1, 0, 1, 128, 128);
        add_pixel(255, 255, 255, 1, 1, 255, 0, 0, 0);
        add_pixel(255, 255, 255, 0, 1, 255, 0, 0, 0);
        add_pixel(255, 255, 255, 0, 1, 255, 0, 0, 0);
        add_pixel(255, 255, 255, 0, 1, 255, 1, 128, 128);
        // Odd width: last column of each row closes nothing
        add_width(12'd3);
        add_pixel(255, 0, 0, 1);
        add_pixel(0, 255, 0, 0);
        add_pixel(0, 0, 255, 0);
        add_pixel(255, 255, 0, 0);
        add_pixel(0, 255, 255, 0);
        // Widths out of range act as the nearest limit
        add_width(12'd0);
        add_pixel(128, 64, 32, 1);
        add_pixel(1, 2, 254, 0);
        add_width(12'hFFF);
        add_pixel(255, 255, 255, 1, 1, 255, 0, 0, 0);
        // Shrink the width mid-row: the row ends after the next pixel
        add_width(12'd6);
        add_pixel(10, 200, 30, 1);
        add_pixel(200, 10, 30, 0);
        add_pixel(30, 10, 200, 0);
        add_pixel(90, 90, 90, 0);
        add_width(12'd2);
        add_pixel(255, 128, 0, 0);
        add_pixel(0, 128, 255, 0);
        add_pixel(77, 77, 77, 0);

        phase_widths = '{12'd2, 12'd4, 12'd2048, 12'd3, 12'd0, 12'd6, 12'd640,
                         12'hFFF, 12'd2, 12'd5, 12'd8, 12'd2};
        phase_widths[8] = 12'($urandom_range(2, 12));
        phase_widths[10] = 12'($urandom_range(2, 12));

        // Hold reset, then release
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with no idling
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WIDTH)
                write_width(plan[i].width);
            else
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
        end

        // Random raster content under rotating idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_width(phase_widths[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(random_pixel(), 1'b0, '0);
        end

        // Drain and settle
        push <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rgbyuv_pkg.sv
rtl/core/rgbyuv_front.sv
rtl/core/rgbyuv_queue.sv
rtl/core/rgbyuv_back.sv
rtl/core/rgb_to_yuv420_converter_core.sv
tb/sv/tb.sv
